/* hw/rtl/sfd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the sync-marker deframer.
// Used by sfd_cfg, sfd_core and the top level; depends on nothing.
package sfd_pkg;

    localparam logic [31:0] SYNC_WORD_RESET = 32'h1ACF_FC1D;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;

    // Event codes on the result
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_GOOD      = 3'd1;
    localparam logic [2:0] EV_CRC_ERR   = 3'd2;
    localparam logic [2:0] EV_BAD_TYPE  = 3'd3;
    localparam logic [2:0] EV_WRONG_TGT = 3'd4;

    // Register indexes on the configuration port
    localparam logic REG_SYNC_WORD = 1'b0;
    localparam logic REG_TARGET_ID = 1'b1;

    // Frame offsets of interest
    localparam logic [9:0] OFF_TYPE   = 10'd10;
    localparam logic [9:0] OFF_TARGET = 10'd11;
    localparam logic [9:0] OFF_LOCK   = 10'd4;

    typedef enum logic [2:0] {
        MODE_SEARCH = 3'b001,
        MODE_READ   = 3'b010,
        MODE_SKIP   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [7:0]  dest_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic [9:0] frame_offset;
        logic [2:0] event_res;
        logic [7:0] frame_type;
        logic [9:0] frame_length;
        logic       frame_end;
    } res_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Total frame length by packet type, zero for an unknown type
    function automatic logic [9:0] type_length(input logic [7:0] t);
        logic [9:0] len;
        case (t)
            8'h10:                       len = 10'd120;
            8'hFB:                       len = 10'd574;
            8'hC0:                       len = 10'd22;
            8'hA0, 8'h81, 8'h85, 8'h87,
            8'hD0:                       len = 10'd14;
            8'hE0:                       len = 10'd120;
            8'hEC:                       len = 10'd16;
            default:                     len = 10'd0;
        endcase
        return len;
    endfunction

    // Sync byte k, byte 0 in the top bits of the word
    function automatic logic [7:0] sync_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] sb;
        case (k)
            2'd0:    sb = w[31:24];
            2'd1:    sb = w[23:16];
            2'd2:    sb = w[15:8];
            default: sb = w[7:0];
        endcase
        return sb;
    endfunction

endpackage

/* hw/rtl/sfd_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers of the deframer behind a small APB-style port.
// Depends on sfd_pkg.
module sfd_cfg
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    logic [31:0] sync_word_reg;
    logic [7:0]  dest_id_reg;
    logic        wr_en;
    logic        reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg <= SYNC_WORD_RESET;
            dest_id_reg   <= 8'd0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SYNC_WORD: sync_word_reg <= pwdata;
                REG_TARGET_ID: dest_id_reg   <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_SYNC_WORD: prdata = sync_word_reg;
            REG_TARGET_ID: prdata = {24'd0, dest_id_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.sync_word = sync_word_reg;
    assign cfg.dest_id   = dest_id_reg;

endmodule

/* hw/rtl/sfd_core.sv */
`timescale 1ns / 1ps
// Per-byte deframer step: sync hunt, type and target checks, CRC and frame state.
// Depends on sfd_pkg.
module sfd_core
    import sfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output res_t       res
);

    mode_t       mode_reg, mode_next;
    logic [1:0]  matched_reg, matched_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  elen_reg, elen_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;

    logic [15:0] crc_step;
    logic [7:0]  sync0;
    logic [7:0]  sync_k;

    assign crc_step = crc_byte(crc_reg, rx_byte);
    assign sync0    = sync_byte(cfg.sync_word, 2'd0);
    assign sync_k   = sync_byte(cfg.sync_word, matched_reg);

    // Work out the result and the next state for the byte at the input register
    always_comb begin
        logic [9:0]  tlen;
        logic [9:0]  elen_eff;
        logic [10:0] pos_p3;
        logic [10:0] pos_p1;
        logic        skip_now;
        logic        last;

        tlen      = 10'd0;
        elen_eff  = elen_reg;
        pos_p3    = {1'b0, pos_reg} + 11'd3;
        pos_p1    = {1'b0, pos_reg} + 11'd1;
        skip_now  = (mode_reg == MODE_SKIP);
        last      = 1'b0;

        mode_next    = mode_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        elen_next    = elen_reg;
        held_next    = held_reg;
        crc_next     = crc_reg;
        rcrc_next    = rcrc_reg;

        res.data_byte    = rx_byte;
        res.in_frame     = 1'b0;
        res.frame_offset = 10'd0;
        res.event_res    = EV_NONE;
        res.frame_type   = 8'd0;
        res.frame_length = 10'd0;
        res.frame_end    = 1'b0;

        unique case (mode_reg)
            MODE_READ, MODE_SKIP: begin
                res.in_frame     = 1'b1;
                res.frame_offset = pos_reg;
                if (pos_reg == OFF_TYPE) begin
                    held_next = rx_byte;
                end
                if (mode_reg == MODE_READ) begin
                    if (pos_reg < 10'd12 || (elen_reg >= 10'd3 && pos_p3 <= {1'b0, elen_reg}))
                    begin
                        crc_next = crc_step;
                    end
                    rcrc_next = {rcrc_reg[7:0], rx_byte};
                end
                if (pos_reg >= OFF_TYPE) begin
                    res.frame_type = held_next;
                end
                // Type and target decided on byte 11
                if (mode_reg == MODE_READ && pos_reg == OFF_TARGET && elen_reg == 10'd0) begin
                    tlen = type_length(held_next);
                    if (tlen == 10'd0) begin
                        res.event_res = EV_BAD_TYPE;
                        res.frame_end = 1'b1;
                    end else begin
                        elen_eff = tlen;
                        if (rx_byte != cfg.dest_id) begin
                            res.event_res = EV_WRONG_TGT;
                            skip_now      = 1'b1;
                        end
                    end
                end
                if (res.event_res == EV_BAD_TYPE) begin
                    // Abort and recheck this byte as the first sync byte
                    mode_next    = MODE_SEARCH;
                    matched_next = (rx_byte == sync0) ? 2'd1 : 2'd0;
                    pos_next     = 10'd0;
                    elen_next    = 10'd0;
                end else begin
                    res.frame_length = elen_eff;
                    last = (elen_eff != 10'd0) && (pos_p1 >= {1'b0, elen_eff});
                    if (last) begin
                        res.frame_end = 1'b1;
                        if (!skip_now) begin
                            res.event_res = (rcrc_next == crc_next) ? EV_GOOD : EV_CRC_ERR;
                        end
                        mode_next    = MODE_SEARCH;
                        matched_next = 2'd0;
                        pos_next     = 10'd0;
                        elen_next    = 10'd0;
                    end else begin
                        mode_next = skip_now ? MODE_SKIP : MODE_READ;
                        pos_next  = pos_p1[9:0];
                        elen_next = elen_eff;
                    end
                end
            end
            default: begin
                // Hunt for the sync word
                mode_next = MODE_SEARCH;
                if (rx_byte == sync_k) begin
                    res.in_frame     = 1'b1;
                    res.frame_offset = {8'd0, matched_reg};
                    if (matched_reg == 2'd3) begin
                        mode_next    = MODE_READ;
                        matched_next = 2'd0;
                        pos_next     = OFF_LOCK;
                        elen_next    = 10'd0;
                        held_next    = 8'd0;
                        crc_next     = CRC_INIT;
                        rcrc_next    = 16'd0;
                    end else begin
                        matched_next = matched_reg + 2'd1;
                    end
                end else if (rx_byte == sync0) begin
                    res.in_frame = 1'b1;
                    matched_next = 2'd1;
                end else begin
                    matched_next = 2'd0;
                end
            end
        endcase
    end

    // Advance the frame state when the item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_SEARCH;
            matched_reg <= 2'd0;
            pos_reg     <= 10'd0;
            elen_reg    <= 10'd0;
            held_reg    <= 8'd0;
            crc_reg     <= CRC_INIT;
            rcrc_reg    <= 16'd0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
            elen_reg    <= elen_next;
            held_reg    <= held_next;
            crc_reg     <= crc_next;
            rcrc_reg    <= rcrc_next;
        end
    end

    a_search_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SEARCH |-> pos_reg == 10'd0 && elen_reg == 10'd0)
        else $error("search mode with frame position or length set");

    a_skip_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SKIP |-> elen_reg != 10'd0 && pos_reg < elen_reg)
        else $error("skipping without a known frame length");

    a_lock_start: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && mode_reg == MODE_SEARCH && mode_next == MODE_READ
        |=> pos_reg == OFF_LOCK && crc_reg == CRC_INIT)
        else $error("frame lock did not restart position and CRC");

endmodule

/* hw/rtl/sync_frame_deframer_crc16_top.sv */
`timescale 1ns / 1ps
// Top level of the sync-marker deframer with CRC-16 check.
// Depends on sfd_pkg, sfd_cfg and sfd_core.
//
// Usage:
//   s_tdata carries one received link byte per item. Each accepted item gives
//   exactly one result on the m_ channel: the byte echoed with its frame
//   offset, packet type, frame length and event code. m_tlast is high on the
//   byte that ends a frame attempt (good, CRC mismatch, unknown type, or the
//   last byte of a skipped wrong-target frame). The sync word (address 0) and
//   the destination ID (address 4) must be written over APB only while the
//   block is idle (not enforced by the block); reads return the stored values.
// Timing:
//   An item is held in the input register, where the frame step is worked
//   out, and is then loaded into the result register, which drives m_tvalid.
//   One item per cycle is sustained while m_tready is high; the limit is the
//   combinational CRC byte step plus the length lookup.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers, restores the
//   register defaults and returns the block to sync search. While m_tready is
//   low the result holds, the input register keeps one more item, and
//   s_tready then falls until the result is taken.
module sync_frame_deframer_crc16_top
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] data_byte, [17:8] frame_offset,
                                   // [25:18] frame_type, [35:26] frame_length, zero pad
    output logic [3:0]  m_tuser,   // [0] in_frame, [3:1] event_res
    output logic        m_tlast,   // frame_end
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    res_t       step_res;
    res_t       out_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic [7:0] in_byte_reg;
    logic       s_accept;
    logic       move;

    assign pready = 1'b1;

    sfd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (move),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Handshake: the item moves on when the result register is free or being taken
    assign move     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | move;
    assign s_accept = s_tvalid & s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept | (in_valid_reg & ~move);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= move | (out_valid_reg & ~m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.frame_length, out_reg.frame_type,
                       out_reg.frame_offset, out_reg.data_byte};
    assign m_tuser  = {out_reg.event_res, out_reg.in_frame};
    assign m_tlast  = out_reg.frame_end;

    a_end_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_reg.in_frame)
        else $error("frame end on a byte outside a frame");

    a_bad_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.event_res == EV_BAD_TYPE || out_reg.event_res == EV_WRONG_TGT)
        |-> out_reg.frame_offset == OFF_TARGET)
        else $error("type or target event away from byte 11");

    a_crc_event_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.event_res == EV_GOOD || out_reg.event_res == EV_CRC_ERR)
        |-> m_tlast && out_reg.frame_offset + 10'd1 == out_reg.frame_length)
        else $error("CRC verdict not on the last byte of the frame");

    a_offset_in_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.frame_length != 10'd0 |-> out_reg.frame_offset < out_reg.frame_length)
        else $error("frame offset beyond frame length");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sync_frame_deframer_crc16_top: it streams link bytes
// and predicts every echoed result. Needs sfd_pkg and the deframer RTL only.
module tb;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam logic [2:0]  ADDR_SYNC   = {REG_SYNC_WORD, 2'b00};
    localparam logic [2:0]  ADDR_TARGET = {REG_TARGET_ID, 2'b00};
    localparam logic [7:0]  SHORT_TYPES [5] = '{8'hA0, 8'h81, 8'h85, 8'h87, 8'hD0};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] data_byte, [17:8] frame_offset,
                                    // [25:18] frame_type, [35:26] frame_length, zero pad
    logic [3:0]  m_tuser;           // [0] in_frame, [3:1] event_res
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and of the deframer state
    logic [31:0] cfg_sync   = SYNC_WORD_RESET;
    logic [7:0]  cfg_target = 8'h00;
    mode_t       rx_mode    = MODE_SEARCH;
    logic [2:0]  sync_cnt   = 3'd0;
    logic [9:0]  pos        = 10'd0;
    logic [9:0]  flen_exp   = 10'd0;
    logic [7:0]  type_held  = 8'h00;
    logic [15:0] crc_run    = CRC_INIT;
    logic [15:0] crc_rx     = 16'h0000;

    res_t        predicted_res_q [$];
    res_t        want;
    int unsigned idle_pct    = 0;
    int unsigned stall_left  = 0;
    int unsigned cycles      = 0;
    int unsigned bytes_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned n_good      = 0;
    int unsigned n_crc_err   = 0;
    int unsigned n_bad_type  = 0;
    int unsigned n_wrong_tgt = 0;

    sync_frame_deframer_crc16_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // CRC-16/CCITT-FALSE, one data bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Total frame length per packet type, zero when the type is not known
    function automatic int unsigned frame_len_of(input logic [7:0] t);
        int unsigned n;
        if (t == 8'hA0 || t == 8'h81 || t == 8'h85 || t == 8'h87 || t == 8'hD0) begin
            n = 14;
        end else if (t == 8'h10 || t == 8'hE0) begin
            n = 120;
        end else if (t == 8'hFB) begin
            n = 574;
        end else if (t == 8'hC0) begin
            n = 22;
        end else if (t == 8'hEC) begin
            n = 16;
        end else begin
            n = 0;
        end
        return n;
    endfunction

    function automatic logic [7:0] sync_byte_of(input int unsigned k);
        return cfg_sync[31 - 8 * k -: 8];
    endfunction

    function automatic void restart_hunt(input logic [2:0] matched);
        rx_mode  = MODE_SEARCH;
        sync_cnt = matched;
        pos      = 10'd0;
        flen_exp = 10'd0;
    endfunction

    // Advance the predicted deframer by one byte and return its result
    function automatic res_t deframe_step(input logic [7:0] b);
        res_t        r;
        int unsigned p;
        int unsigned len;
        int unsigned k;
        r = '0;
        r.data_byte = b;
        if (rx_mode == MODE_READ || rx_mode == MODE_SKIP) begin
            p = pos;
            r.in_frame     = 1'b1;
            r.frame_offset = pos;
            if (p == OFF_TYPE) begin
                type_held = b;
            end
            if (rx_mode == MODE_READ) begin
                if (p < 12 || (flen_exp >= 3 && p + 3 <= flen_exp)) begin
                    crc_run = crc16_step(crc_run, b);
                end
                crc_rx = {crc_rx[7:0], b};
            end
            if (p >= OFF_TYPE) begin
                r.frame_type = type_held;
            end
            // Type and target are decided together on byte 11
            if (rx_mode == MODE_READ && p == OFF_TARGET && flen_exp == 0) begin
                len = frame_len_of(type_held);
                if (len == 0) begin
                    r.event_res = EV_BAD_TYPE;
                    r.frame_end = 1'b1;
                    restart_hunt((b == sync_byte_of(0)) ? 3'd1 : 3'd0);
                    return r;
                end
                flen_exp = 10'(len);
                if (b != cfg_target) begin
                    r.event_res = EV_WRONG_TGT;
                    rx_mode     = MODE_SKIP;
                end
            end
            r.frame_length = flen_exp;
            if (flen_exp != 0 && p + 1 >= flen_exp) begin
                r.frame_end = 1'b1;
                if (rx_mode == MODE_READ) begin
                    r.event_res = (crc_rx == crc_run) ? EV_GOOD : EV_CRC_ERR;
                end
                restart_hunt(3'd0);
            end else begin
                pos = 10'(p + 1);
            end
        end else begin
            k = sync_cnt[1:0];
            rx_mode = MODE_SEARCH;
            if (b == sync_byte_of(k)) begin
                r.in_frame     = 1'b1;
                r.frame_offset = 10'(k);
                if (k == 3) begin
                    rx_mode   = MODE_READ;
                    sync_cnt  = 3'd4;
                    pos       = OFF_LOCK;
                    flen_exp  = 10'd0;
                    type_held = 8'h00;
                    crc_run   = CRC_INIT;
                    crc_rx    = 16'h0000;
                end else begin
                    sync_cnt = 3'(k + 1);
                end
            end else if (b == sync_byte_of(0)) begin
                r.in_frame     = 1'b1;
                r.frame_offset = 10'd0;
                sync_cnt       = 3'd1;
            end else begin
                sync_cnt = 3'd0;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive result back-pressure in bursts and check each accepted result
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(16, 1) - 1;
        end else begin
            m_tready <= 1'b1;
        end

        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_res_q.size() == 0) begin
                $error("result with no byte outstanding: data_byte %0d", m_tdata[7:0]);
                mismatches++;
            end else begin
                want = predicted_res_q[0];
                predicted_res_q.delete(0);
                check_field("data_byte",    want.data_byte,    m_tdata[7:0]);
                check_field("in_frame",     want.in_frame,     m_tuser[0]);
                check_field("frame_offset", want.frame_offset, m_tdata[17:8]);
                check_field("event_res",    want.event_res,    m_tuser[3:1]);
                check_field("frame_type",   want.frame_type,   m_tdata[25:18]);
                check_field("frame_length", want.frame_length, m_tdata[35:26]);
                check_field("frame_end",    want.frame_end,    m_tlast);
            end
            case (m_tuser[3:1])
                EV_GOOD:      n_good++;
                EV_CRC_ERR:   n_crc_err++;
                EV_BAD_TYPE:  n_bad_type++;
                EV_WRONG_TGT: n_wrong_tgt++;
                default: ;
            endcase
        end
    end

    // Offer one byte, hold it until taken, then predict its result
    task automatic send_byte(input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predicted_res_q = {predicted_res_q, deframe_step(b)};
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every result is back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (predicted_res_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup and access phases, then idle before the next transfer
    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [31:0] exp_v);
        logic [31:0] rd;
        apb_xfer(1'b0, addr, 32'd0, rd);
        if (rd !== exp_v) begin
            $error("register at %0d: expected %08h, got %08h", addr, exp_v, rd);
            mismatches++;
        end
    endtask

    // Write a register while the block is idle, read it back, update the predictor
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        logic [31:0] rd;
        drain();
        apb_xfer(1'b1, addr, val, rd);
        if (addr == ADDR_SYNC) begin
            cfg_sync = val;
            check_reg(addr, val);
        end else begin
            cfg_target = val[7:0];
            check_reg(addr, {24'd0, val[7:0]});
        end
    endtask

    // Build one frame from the current registers; cut > 0 truncates it
    task automatic send_frame(input logic [7:0] ptype, input bit tgt_ok, input bit crc_ok,
                              input int unsigned cut);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        int unsigned len;
        len = frame_len_of(ptype);
        for (int i = 0; i < 4; i++) begin
            fb = {fb, sync_byte_of(i)};
        end
        repeat (6) fb = {fb, 8'($urandom_range(255, 0))};
        fb = {fb, ptype};
        if (len == 0) begin
            // Byte after an unknown type is sometimes the first sync byte
            fb = {fb, ($urandom_range(1, 0) ? sync_byte_of(0) : 8'($urandom_range(255, 0)))};
        end else begin
            fb = {fb, (tgt_ok ? cfg_target : cfg_target ^ 8'($urandom_range(255, 1)))};
            while (fb.size() < len - 2) fb = {fb, 8'($urandom_range(255, 0))};
            crc = CRC_INIT;
            for (int i = 4; i <= len - 3; i++) begin
                crc = crc16_step(crc, fb[i]);
            end
            if (!crc_ok) begin
                crc = crc ^ 16'($urandom_range(65535, 1));
            end
            fb = {fb, crc[15:8]};
            fb = {fb, crc[7:0]};
        end
        if (cut != 0 && cut < fb.size()) begin
            fb = fb[0:cut - 1];
        end
        foreach (fb[j]) begin
            send_byte(fb[j]);
        end
    endtask

    task automatic test_reset_registers;
        check_reg(ADDR_SYNC, SYNC_WORD_RESET);
        check_reg(ADDR_TARGET, 32'd0);
    endtask

    // Byte extremes, a broken sync restart, and an unknown type rechecked as sync
    task automatic test_sync_hunt;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sync_byte_of(0));
        send_byte(sync_byte_of(1));
        for (int i = 0; i < 4; i++) begin
            send_byte(sync_byte_of(i));
        end
        repeat (6) send_byte(8'($urandom_range(255, 0)));
        send_byte(8'h55);
        send_byte(sync_byte_of(0));
        send_byte(~sync_byte_of(0));
    endtask

    // Mostly well-formed frames with random content, plus noise and cut frames
    task automatic test_random_frames(input int unsigned stop_at);
        logic [7:0]  t;
        int unsigned pick;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99, 0) < 15) begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255, 0)));
            end
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                t = SHORT_TYPES[$urandom_range(4, 0)];
            end else if (pick < 62) begin
                t = 8'hEC;
            end else if (pick < 72) begin
                t = 8'hC0;
            end else if (pick < 77) begin
                t = 8'h10;
            end else if (pick < 82) begin
                t = 8'hE0;
            end else begin
                do t = 8'($urandom_range(255, 0)); while (frame_len_of(t) != 0);
            end
            send_frame(t, $urandom_range(99, 0) < 80, $urandom_range(99, 0) < 80,
                       ($urandom_range(99, 0) < 8) ? $urandom_range(13, 1) : 0);
        end
    endtask

    // Longest frame type, so the top offset and length are reached
    task automatic test_longest_frame;
        send_frame(8'hFB, 1'b1, 1'b1, 0);
        send_frame(8'hFB, 1'b1, 1'b0, 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_registers();
        idle_pct = 20;
        test_sync_hunt();
        test_random_frames(200);

        idle_pct = 40;
        write_reg(ADDR_SYNC, 32'hFFFF_FFFF);
        write_reg(ADDR_TARGET, 32'h0000_00FF);
        test_random_frames(330);

        idle_pct = 0;
        write_reg(ADDR_SYNC, 32'h0000_0000);
        write_reg(ADDR_TARGET, 32'h0000_0000);
        test_random_frames(430);

        // Repeated leading sync byte exercises the restart on mismatch
        idle_pct = 25;
        write_reg(ADDR_SYNC, 32'h5A5A_C3E1);
        write_reg(ADDR_TARGET, 32'($urandom_range(255, 0)));
        test_random_frames(500);

        write_reg(ADDR_SYNC, $urandom);
        test_longest_frame();

        // Final stretch at full rate on both sides
        write_reg(ADDR_SYNC, SYNC_WORD_RESET);
        write_reg(ADDR_TARGET, 32'h0000_0042);
        idle_pct = 0;
        test_random_frames(bytes_sent + 100);

        drain();
        repeat (16) @(posedge aclk);
        $display("Streamed %0d bytes over six register settings; events seen:", bytes_sent);
        $display("  %0d good, %0d CRC errors, %0d unknown types, %0d wrong targets",
                 n_good, n_crc_err, n_bad_type, n_wrong_tgt);
        if (mismatches == 0 && predicted_res_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
